>>> sv/krat_pkg.sv
// Shared constants, entry layout and helper functions of the rate audit table.
package krat_pkg;

  localparam int ENTRIES   = 64;
  localparam int KEY_BITS  = 64;
  localparam int TIME_BITS = 32;

  localparam int TIME_W  = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int HIT_W   = 16;
  localparam int EVICT_W = 7;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [1:0] REG_LIMIT  = 2'd0;
  localparam logic [1:0] REG_WINDOW = 2'd1;
  localparam logic [1:0] REG_MAXHIT = 2'd2;

  localparam logic MODE_JUDGE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TIME_W-1:0]   first;
    logic [TIME_W-1:0]   last;
    logic [HIT_W-1:0]    hits;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] now_v,
                                                input logic [TIME_W-1:0] then_v);
    return (now_v >= then_v) ? (now_v - then_v) : '0;
  endfunction

  function automatic logic [HIT_W-1:0] sat_inc(input logic [HIT_W-1:0] v);
    return (v == {HIT_W{1'b1}}) ? v : (v + HIT_W'(1));
  endfunction

  function automatic logic [EVICT_W-1:0] evict_sat(input logic [CNT_W-1:0] c);
    return (32'(c) > 32'd127) ? EVICT_W'(127) : EVICT_W'(c);
  endfunction

endpackage

>>> sv/krat_in_if.sv
// Request channel: mode, client key and current time.
interface krat_in_if
  import krat_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [63:0]         client_key;
  logic [31:0]         now_seconds;

  modport source (output valid, mode, client_key, now_seconds, input ready);
  modport sink   (input valid, mode, client_key, now_seconds, output ready);
endinterface

>>> sv/krat_out_if.sv
// Result channel: verdict and eviction count.
interface krat_out_if
  import krat_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               verdict;
  logic [EVICT_W-1:0] evicted_count;

  modport source (output valid, verdict, evicted_count, input ready);
  modport sink   (input valid, verdict, evicted_count, output ready);
endinterface

>>> sv/krat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module krat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

>>> sv/keyed_rate_audit_table.sv
// Per-client fixed-window rate limiter table: sequencer, entry scan and update.
//
//   channel | dir | handshake        | payload
//   req_i   | in  | valid/ready      | mode, client_key, now_seconds
//   rsp_o   | out | valid/ready      | verdict, evicted_count
//   apb     | in  | psel/penable     | paddr, pwdata, prdata (pready tied high)
//
// An item takes one RAM read per entry through the single table port, then a
// decide/write step; with the limit at zero the scan is skipped.
// The expiry sweep runs inside that same scan; no extra pass is needed.
// Reset clears all valid bits and the entry count at once; no clearing pass.
// A new item is taken while a result waits; decide holds until rsp_o is free.
module keyed_rate_audit_table
  import krat_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  krat_in_if.sink           req_i,
  krat_out_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } state_e;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_e state_q, state_d;

  logic [6:0]          limit_q;
  logic [15:0]         window_q;
  logic [15:0]         maxhit_q;

  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [CNT_W-1:0]    total_q, total_d;

  logic                mode_q;
  logic [KEY_BITS-1:0] key_q;
  logic [TIME_W-1:0]   now_q;

  logic [IDX_W-1:0]    rd_ptr_q;
  logic                issued_q;
  logic                pend_q;
  logic [IDX_W-1:0]    pend_idx_q;

  logic                hit_q;
  logic [IDX_W-1:0]    hit_idx_q;
  logic [TIME_W-1:0]   hit_first_q;
  logic [HIT_W-1:0]    hit_cnt_q;
  logic                hit_last_ge_q;
  logic                hit_last_gt_q;

  logic [ENTRIES-1:0]  exp_mask_q;
  logic [CNT_W-1:0]    exp_cnt_q;
  logic                free_found_q;
  logic [IDX_W-1:0]    free_idx_q;
  logic                avail_found_q;
  logic [IDX_W-1:0]    avail_idx_q;

  logic                out_valid_q;
  logic                out_verdict_q;
  logic [EVICT_W-1:0]  out_evict_q;

  logic                accept;
  logic                cfg_we;
  logic                fire;
  logic                disabled;
  logic                room;
  logic                ent_valid;
  logic                ent_match;
  logic                ent_exp;
  logic [TIME_W-1:0]   unit_then;
  logic [TIME_W-1:0]   unit_elap;
  logic                unit_gt;
  logic                unit_ge;
  logic                ram_re;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  entry_t              ram_wdata;
  entry_t              ram_rdata;
  entry_t              upd_entry;
  logic                verdict_d;
  logic [EVICT_W-1:0]  evict_d;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_LIMIT:  prdata = DATA_W'(limit_q);
      REG_WINDOW: prdata = DATA_W'(window_q);
      REG_MAXHIT: prdata = DATA_W'(maxhit_q);
      default:    prdata = '0;
    endcase
  end

  // Handshakes
  assign req_i.ready         = (state_q == ST_IDLE);
  assign accept              = req_i.valid & req_i.ready;
  assign fire                = (state_q == ST_DECIDE) & (~out_valid_q | rsp_o.ready);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.verdict       = out_verdict_q;
  assign rsp_o.evicted_count = out_evict_q;

  assign disabled = (limit_q == 7'd0);
  assign room     = (32'(total_q) < 32'(limit_q)) && (32'(total_q) < ENTRIES);

  // Table RAM
  assign ram_re = (state_q == ST_SCAN) & ~issued_q;

  krat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // Shared elapsed-time unit
  assign unit_then = (state_q == ST_DECIDE) ? hit_first_q : ram_rdata.last;
  assign unit_elap = elapsed(now_q, unit_then);
  assign unit_gt   = unit_elap > TIME_W'(window_q);
  assign unit_ge   = unit_elap >= TIME_W'(window_q);

  assign ent_valid = valid_q[pend_idx_q];
  assign ent_match = pend_q & ent_valid & (ram_rdata.key == key_q) & ~hit_q;
  assign ent_exp   = pend_q & ent_valid & unit_ge;

  // Entry update for a judged hit
  always_comb begin
    upd_entry.key   = key_q;
    upd_entry.first = hit_first_q;
    upd_entry.last  = now_q;
    upd_entry.hits  = sat_inc(hit_cnt_q);
    if (hit_cnt_q < maxhit_q) begin
      if (unit_gt) begin
        upd_entry.first = now_q;
        upd_entry.hits  = HIT_W'(1);
      end
    end else if (hit_last_gt_q) begin
      upd_entry.first = now_q;
      upd_entry.hits  = HIT_W'(1);
    end
  end

  // Decide
  always_comb begin
    verdict_d = 1'b1;
    evict_d   = '0;
    valid_d   = valid_q;
    total_d   = total_q;
    ram_we    = 1'b0;
    ram_waddr = hit_idx_q;
    ram_wdata = upd_entry;
    if (disabled) begin
      verdict_d = (mode_q == MODE_JUDGE);
    end else if (mode_q == MODE_QUERY) begin
      verdict_d = hit_q & (hit_cnt_q >= maxhit_q) & hit_last_ge_q;
    end else if (hit_q) begin
      ram_we    = 1'b1;
      verdict_d = (hit_cnt_q < maxhit_q) | hit_last_gt_q;
    end else begin
      ram_wdata.key   = key_q;
      ram_wdata.first = now_q;
      ram_wdata.last  = now_q;
      ram_wdata.hits  = HIT_W'(1);
      if (room) begin
        ram_we             = 1'b1;
        ram_waddr          = free_idx_q;
        valid_d[free_idx_q] = 1'b1;
        total_d            = total_q + CNT_W'(1);
      end else begin
        evict_d = evict_sat(exp_cnt_q);
        valid_d = valid_q & ~exp_mask_q;
        total_d = total_q - exp_cnt_q;
        if (exp_cnt_q != '0) begin
          ram_we               = 1'b1;
          ram_waddr            = avail_idx_q;
          valid_d[avail_idx_q] = 1'b1;
          total_d              = total_q - exp_cnt_q + CNT_W'(1);
        end
      end
    end
    ram_we = ram_we & fire;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = disabled ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pend_q && (pend_idx_q == LAST_IDX)) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      limit_q       <= 7'd0;
      window_q      <= 16'd60;
      maxhit_q      <= 16'd10;
      valid_q       <= '0;
      total_q       <= '0;
      issued_q      <= 1'b0;
      pend_q        <= 1'b0;
      hit_q         <= 1'b0;
      exp_mask_q    <= '0;
      exp_cnt_q     <= '0;
      free_found_q  <= 1'b0;
      avail_found_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        case (paddr[3:2])
          REG_LIMIT:  limit_q  <= pwdata[6:0];
          REG_WINDOW: window_q <= pwdata[15:0];
          REG_MAXHIT: maxhit_q <= pwdata[15:0];
          default: ;
        endcase
      end
      if (accept) begin
        issued_q      <= 1'b0;
        pend_q        <= 1'b0;
        hit_q         <= 1'b0;
        exp_mask_q    <= '0;
        exp_cnt_q     <= '0;
        free_found_q  <= 1'b0;
        avail_found_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        pend_q <= ram_re;
        if (ram_re && (rd_ptr_q == LAST_IDX)) begin
          issued_q <= 1'b1;
        end
        if (ent_match) begin
          hit_q <= 1'b1;
        end
        if (ent_exp) begin
          exp_mask_q[pend_idx_q] <= 1'b1;
          exp_cnt_q              <= exp_cnt_q + CNT_W'(1);
        end
        if (pend_q && !ent_valid) begin
          free_found_q <= 1'b1;
        end
        if (pend_q && (!ent_valid || ent_exp)) begin
          avail_found_q <= 1'b1;
        end
      end
      if (fire) begin
        valid_q     <= valid_d;
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= req_i.mode;
      key_q    <= req_i.client_key[KEY_BITS-1:0];
      now_q    <= req_i.now_seconds[TIME_W-1:0];
      rd_ptr_q <= '0;
    end else if (state_q == ST_SCAN) begin
      if (ram_re) begin
        rd_ptr_q <= rd_ptr_q + IDX_W'(1);
      end
      pend_idx_q <= rd_ptr_q;
      if (ent_match) begin
        hit_idx_q     <= pend_idx_q;
        hit_first_q   <= ram_rdata.first;
        hit_cnt_q     <= ram_rdata.hits;
        hit_last_ge_q <= unit_ge;
        hit_last_gt_q <= unit_gt;
      end
      if (pend_q && !ent_valid && !free_found_q) begin
        free_idx_q <= pend_idx_q;
      end
      if (pend_q && (!ent_valid || ent_exp) && !avail_found_q) begin
        avail_idx_q <= pend_idx_q;
      end
    end
    if (fire) begin
      out_verdict_q <= verdict_d;
      out_evict_q   <= evict_d;
    end
  end

endmodule
